// ===== src/rmf_pkg.sv =====
// shared types and constants for the fraction alu
package rmf_pkg;

  localparam int unsigned FieldWidth = 16;
  localparam int unsigned ProdWidth  = 2 * FieldWidth;
  localparam int unsigned NumWidth   = ProdWidth + 1;
  localparam int unsigned WholeWidth = 33;
  localparam int unsigned RemWidth   = 32;
  localparam int unsigned DenWidth   = 31;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned CntWidth   = $clog2(NumWidth + 1);

  typedef enum logic [1:0] {
    OpAdd = 2'd0,
    OpSub = 2'd1,
    OpMul = 2'd2,
    OpDiv = 2'd3
  } op_e;

  // classified request handed from front to back
  typedef struct packed {
    logic                err;
    logic                neg;
    logic [NumWidth-1:0] nmag;
    logic [ProdWidth-1:0] dmag;
  } job_t;

  typedef struct packed {
    logic push;
    logic full;
  } q_ctl_t;

endpackage

// ===== src/rmf_front.sv =====
// front end: accepts a request and forms the signed cross products
module rmf_front import rmf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [1:0]            op_i,
  input  logic [FieldWidth-1:0] a_num_i,
  input  logic [FieldWidth-1:0] a_den_i,
  input  logic [FieldWidth-1:0] b_num_i,
  input  logic [FieldWidth-1:0] b_den_i,
  input  logic                  q_full_i,
  output logic                  busy_o,
  output logic                  push_o,
  output job_t                  job_o
);

  logic                  st1_q, st1_d;
  logic                  st2_q, st2_d;
  op_e                   op_q;
  logic [FieldWidth-1:0] an_q, ad_q, bn_q, bd_q;
  logic                  err_q;
  logic [ProdWidth-1:0]  m1_q, m2_q;
  logic [ProdWidth-1:0]  m1, m2;
  logic [FieldWidth-1:0] x1, y1, x2, y2;
  logic                  s1_q, s2_q, dneg_q;
  logic                  s1, s2, dneg;
  logic [ProdWidth-1:0]  dm_q, dm;
  logic [FieldWidth-1:0] dx, dy;
  logic                  accept;
  logic                  e_an, e_ad, e_bn, e_bd;

  function automatic logic [FieldWidth-1:0] mag_f(input logic [FieldWidth-1:0] v);
    mag_f = v[FieldWidth-1] ? (~v + 1'b1) : v;
  endfunction

  assign busy_o = st1_q | st2_q;
  assign accept = start_i & ~busy_o;
  assign e_an = an_q[FieldWidth-1];
  assign e_ad = ad_q[FieldWidth-1];
  assign e_bn = bn_q[FieldWidth-1];
  assign e_bd = bd_q[FieldWidth-1];

  // operand selection per operation
  always_comb begin
    x1 = mag_f(an_q);
    y1 = mag_f(bd_q);
    x2 = mag_f(bn_q);
    y2 = mag_f(ad_q);
    dx = mag_f(ad_q);
    dy = mag_f(bd_q);
    s1 = e_an ^ e_bd;
    s2 = (e_bn ^ e_ad) ^ (op_q == OpSub);
    dneg = e_ad ^ e_bd;
    unique case (op_q)
      OpMul: begin
        y1 = mag_f(bn_q);
        s1 = e_an ^ e_bn;
      end
      OpDiv: begin
        dy = mag_f(bn_q);
        dneg = e_ad ^ e_bn;
      end
      default: ;
    endcase
    m1 = ProdWidth'(x1) * ProdWidth'(y1);
    m2 = ProdWidth'(x2) * ProdWidth'(y2);
    dm = ProdWidth'(dx) * ProdWidth'(dy);
  end

  // stage two: combine the products
  always_comb begin
    job_o.err = err_q;
    job_o.dmag = dm_q;
    job_o.neg = s1_q;
    job_o.nmag = NumWidth'(m1_q);
    if (op_q == OpAdd || op_q == OpSub) begin
      if (s1_q == s2_q) begin
        job_o.nmag = NumWidth'(m1_q) + NumWidth'(m2_q);
      end else if (m1_q >= m2_q) begin
        job_o.nmag = NumWidth'(m1_q - m2_q);
      end else begin
        job_o.neg = s2_q;
        job_o.nmag = NumWidth'(m2_q - m1_q);
      end
    end
    job_o.neg = (job_o.neg ^ dneg_q) & (job_o.nmag != '0);
  end

  assign push_o = st2_q & ~q_full_i;
  assign st1_d = accept;
  assign st2_d = st1_q | (st2_q & q_full_i);

  // request capture and product registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= op_e'(op_i);
      an_q <= a_num_i;
      ad_q <= a_den_i;
      bn_q <= b_num_i;
      bd_q <= b_den_i;
    end
    if (st1_q) begin
      m1_q <= m1;
      m2_q <= m2;
      dm_q <= dm;
      s1_q <= s1;
      s2_q <= s2;
      dneg_q <= dneg;
      err_q <= (ad_q == '0) | (bd_q == '0) | ((op_q == OpDiv) & (bn_q == '0));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st1_q <= 1'b0;
      st2_q <= 1'b0;
    end else begin
      st1_q <= st1_d;
      st2_q <= st2_d;
    end
  end

endmodule

// ===== src/rmf_queue.sv =====
// short queue between classification and the gcd/divide engine
module rmf_queue import rmf_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  q_ctl_t ctl_i,
  input  job_t   job_i,
  input  logic   pop_i,
  output logic   full_o,
  output logic   valid_o,
  output job_t   job_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  job_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [PtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (PtrW+1)'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem_q[wp_q] <= job_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (ctl_i.push) begin
        wp_q <= wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= rp_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrW+1)'(ctl_i.push) - (PtrW+1)'(pop_i);
    end
  end

endmodule

// ===== src/rmf_back.sv =====
// back end: euclid gcd by shared restoring divider, reduction and mixed split
module rmf_back import rmf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  job_t                  job_i,
  output logic                  pop_o,
  output logic                  done_o,
  output logic [WholeWidth-1:0] whole_o,
  output logic [RemWidth-1:0]   rem_num_o,
  output logic [DenWidth-1:0]   res_den_o,
  output logic                  status_o
);

  typedef enum logic [6:0] {
    StIdle = 7'b0000001,
    StGcd  = 7'b0000010,
    StDivN = 7'b0000100,
    StDivD = 7'b0001000,
    StSplt = 7'b0010000,
    StDiv  = 7'b0100000,
    StOut  = 7'b1000000
  } state_e;

  state_e               state_q, state_d;
  logic                 neg_q;
  logic [NumWidth-1:0]  n_q, d_q, g_q;
  // divider: dividend shifts into quotient, partial remainder in r
  logic [NumWidth-1:0]  dq_q, dv_q, r_q;
  logic [CntWidth-1:0]  cnt_q;
  logic [NumWidth:0]    trial;
  logic [NumWidth-1:0]  r_sh;
  logic                 div_last;

  assign r_sh  = {r_q[NumWidth-2:0], dq_q[NumWidth-1]};
  assign trial = {1'b0, r_sh} - {1'b0, dv_q};
  assign div_last = (cnt_q == CntWidth'(NumWidth - 1));
  assign pop_o = (state_q == StIdle) & valid_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (valid_i) state_d = job_i.err ? StOut : StGcd;
      StGcd:  if (dv_q == '0) state_d = StDivN;
              else state_d = StDiv;
      StDiv:  if (div_last) state_d = StGcd;
      StDivN: if (div_last) state_d = StDivD;
      StDivD: if (div_last) state_d = StSplt;
      StSplt: if (div_last) state_d = StOut;
      StOut:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: if (valid_i) begin
        neg_q <= job_i.neg;
        status_o <= job_i.err;
        n_q <= job_i.nmag;
        d_q <= NumWidth'(job_i.dmag);
        // euclid pair (a, b) = (nmag, dmag) held in g/dv
        g_q <= job_i.nmag;
        dq_q <= job_i.nmag;
        dv_q <= NumWidth'(job_i.dmag);
        r_q <= '0;
        cnt_q <= '0;
      end
      StGcd: begin
        cnt_q <= '0;
        r_q <= '0;
        if (dv_q == '0) begin
          dq_q <= n_q;
          dv_q <= g_q;
        end else begin
          dq_q <= g_q;
        end
      end
      default: ;
    endcase
    if (state_q == StDiv || state_q == StDivN || state_q == StDivD ||
        state_q == StSplt) begin
      cnt_q <= cnt_q + 1'b1;
      if (!trial[NumWidth]) begin
        r_q <= trial[NumWidth-1:0];
        dq_q <= {dq_q[NumWidth-2:0], 1'b1};
      end else begin
        r_q <= r_sh;
        dq_q <= {dq_q[NumWidth-2:0], 1'b0};
      end
    end
    if (state_q == StDiv && div_last) begin
      // a <- b, b <- a mod b
      g_q <= dv_q;
      dv_q <= trial[NumWidth] ? r_sh : trial[NumWidth-1:0];
    end
    if (state_q == StDivN && div_last) begin
      n_q <= {dq_q[NumWidth-2:0], ~trial[NumWidth]};
      dq_q <= d_q;
      r_q <= '0;
      cnt_q <= '0;
    end
    if (state_q == StDivD && div_last) begin
      d_q <= {dq_q[NumWidth-2:0], ~trial[NumWidth]};
      dq_q <= n_q;
      dv_q <= {dq_q[NumWidth-2:0], ~trial[NumWidth]};
      r_q <= '0;
      cnt_q <= '0;
    end
    if (state_q == StSplt && div_last) begin
      n_q <= {dq_q[NumWidth-2:0], ~trial[NumWidth]};
      r_q <= trial[NumWidth] ? r_sh : trial[NumWidth-1:0];
    end
    if (state_q == StOut) begin
      if (status_o) begin
        whole_o <= '0;
        rem_num_o <= '0;
        res_den_o <= '0;
      end else begin
        whole_o <= neg_q ? WholeWidth'(~n_q + 1'b1) : WholeWidth'(n_q);
        rem_num_o <= neg_q ? RemWidth'(~r_q + 1'b1) : RemWidth'(r_q);
        res_den_o <= DenWidth'(d_q);
      end
    end
  end

  // state and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_o <= 1'b0;
    end else begin
      state_q <= state_d;
      done_o <= (state_q == StOut);
    end
  end

endmodule

// ===== src/rational_mixed_fraction_alu.sv =====
// top level of the fraction alu
// A request is taken when start is high and busy low; busy then stays high while
// the cross products are formed in stages st1 and st2, and longer while the
// two-entry queue is full, after which the front end can take the next request. The
// back end runs euclid's algorithm with one shared bit-serial restoring divider (each
// remainder step is a setup state StGcd and a divide in StDiv), then one more setup
// state and three more divisions (StDivN, StDivD, StSplt) to reduce and split.
// The result appears for one cycle with done_o high and cannot be held off.
module rational_mixed_fraction_alu import rmf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            op_i,
  input  logic [FieldWidth-1:0] a_num_i,
  input  logic [FieldWidth-1:0] a_den_i,
  input  logic [FieldWidth-1:0] b_num_i,
  input  logic [FieldWidth-1:0] b_den_i,
  output logic                  done_o,
  output logic [WholeWidth-1:0] whole_o,
  output logic [RemWidth-1:0]   rem_num_o,
  output logic [DenWidth-1:0]   res_den_o,
  output logic                  status_o
);

  q_ctl_t qctl;
  job_t   fjob, bjob;
  logic   q_full, q_valid, pop, fbusy;

  assign busy = fbusy;
  assign qctl.full = q_full;

  rmf_front u_front (
    .clk_i, .rst_ni, .start_i(start), .op_i, .a_num_i, .a_den_i, .b_num_i, .b_den_i,
    .q_full_i(qctl.full), .busy_o(fbusy), .push_o(qctl.push), .job_o(fjob)
  );

  rmf_queue u_queue (
    .clk_i, .rst_ni, .ctl_i(qctl), .job_i(fjob), .pop_i(pop),
    .full_o(q_full), .valid_o(q_valid), .job_o(bjob)
  );

  rmf_back u_back (
    .clk_i, .rst_ni, .valid_i(q_valid), .job_i(bjob), .pop_o(pop),
    .done_o, .whole_o, .rem_num_o, .res_den_o, .status_o
  );

  // never push into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) qctl.push |-> !q_full)
    else $error("push into full queue");

  // never pop an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> q_valid)
    else $error("pop from empty queue");

  // an error result carries a zero denominator
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o) |-> (res_den_o == '0))
    else $error("error result with nonzero denominator");

endmodule

// ===== verif/rational_mixed_fraction_alu_checker.sv =====
// checker for the fraction alu: predicts each result and compares it
module rational_mixed_fraction_alu_checker import rmf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  busy_i,
  input  logic [1:0]            op_i,
  input  logic [FieldWidth-1:0] a_num_i,
  input  logic [FieldWidth-1:0] a_den_i,
  input  logic [FieldWidth-1:0] b_num_i,
  input  logic [FieldWidth-1:0] b_den_i,
  input  logic                  done_i,
  input  logic [WholeWidth-1:0] whole_i,
  input  logic [RemWidth-1:0]   rem_num_i,
  input  logic [DenWidth-1:0]   res_den_i,
  input  logic                  status_i,
  output int                    fail_cnt_o,
  output int                    pending_o
);

  typedef struct packed {
    logic [WholeWidth-1:0] whole;
    logic [RemWidth-1:0]   rem_num;
    logic [DenWidth-1:0]   res_den;
    logic                  status;
  } frac_res_t;

  frac_res_t expected_q[$];

  function automatic longint unsigned magnitude(longint x);
    return (x < 0) ? longint'(-x) : longint'(x);
  endfunction

  function automatic longint unsigned gcd_of(longint unsigned a, longint unsigned b);
    longint unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // exact fraction result in sign-magnitude, then truncated to port widths
  function automatic frac_res_t fraction_result(op_e op, logic signed [FieldWidth-1:0] an,
      logic signed [FieldWidth-1:0] ad, logic signed [FieldWidth-1:0] bn,
      logic signed [FieldWidth-1:0] bd);
    frac_res_t r;
    longint san, sad, sbn, sbd;
    logic nneg, dneg, s1, s2;
    longint unsigned nmag, dmag, m1, m2, g, q, rm;
    san = an; sad = ad; sbn = bn; sbd = bd;
    r = '0;
    if (sad == 0 || sbd == 0 || (op == OpDiv && sbn == 0)) begin
      r.status = 1'b1;
      return r;
    end
    dneg = (sad < 0) != (sbd < 0);
    dmag = magnitude(sad) * magnitude(sbd);
    case (op) inside
      OpAdd, OpSub: begin
        s1 = (san < 0) != (sbd < 0);
        s2 = ((sbn < 0) != (sad < 0)) != (op == OpSub);
        m1 = magnitude(san) * magnitude(sbd);
        m2 = magnitude(sbn) * magnitude(sad);
        if (s1 == s2) begin
          nneg = s1; nmag = m1 + m2;
        end else if (m1 >= m2) begin
          nneg = s1; nmag = m1 - m2;
        end else begin
          nneg = s2; nmag = m2 - m1;
        end
      end
      OpMul: begin
        nneg = (san < 0) != (sbn < 0);
        nmag = magnitude(san) * magnitude(sbn);
      end
      default: begin
        nneg = (san < 0) != (sbd < 0);
        nmag = magnitude(san) * magnitude(sbd);
        dneg = (sad < 0) != (sbn < 0);
        dmag = magnitude(sad) * magnitude(sbn);
      end
    endcase
    nneg = (nneg != dneg) && nmag != 0;
    g = gcd_of(nmag, dmag);
    nmag = nmag / g;
    dmag = dmag / g;
    q = nmag / dmag;
    rm = nmag % dmag;
    r.whole   = nneg ? WholeWidth'(-q) : WholeWidth'(q);
    r.rem_num = nneg ? RemWidth'(-rm) : RemWidth'(rm);
    r.res_den = DenWidth'(dmag);
    return r;
  endfunction

  assign pending_o = expected_q.size();

  // predict on each accepted request, compare on each strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    frac_res_t exp_r;
    if (!rst_ni) begin
      fail_cnt_o <= 0;
    end else begin
      if (start_i && !busy_i) begin
        expected_q.push_back(fraction_result(op_e'(op_i), a_num_i, a_den_i, b_num_i,
                                             b_den_i));
      end
      if (done_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result whole=%0h rem=%0h den=%0h st=%0b", $time,
                   whole_i, rem_num_i, res_den_i, status_i);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r != {whole_i, rem_num_i, res_den_i, status_i}) begin
            $display("%0t: mismatch expected whole=%0h rem=%0h den=%0h st=%0b", $time,
                     exp_r.whole, exp_r.rem_num, exp_r.res_den, exp_r.status);
            $display("%0t:          actual   whole=%0h rem=%0h den=%0h st=%0b", $time,
                     whole_i, rem_num_i, res_den_i, status_i);
            fail_cnt_o <= fail_cnt_o + 1;
          end
        end
      end
    end
  end

endmodule

// ===== verif/rational_mixed_fraction_alu_tb.sv =====
// testbench top for the fraction alu: stimulus and verdict
module rational_mixed_fraction_alu_tb;
  import rmf_pkg::*;

  localparam int StallLimit = 20000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic [1:0]            op_i;
  logic [FieldWidth-1:0] a_num_i, a_den_i, b_num_i, b_den_i;
  logic                  done_o;
  logic [WholeWidth-1:0] whole_o;
  logic [RemWidth-1:0]   rem_num_o;
  logic [DenWidth-1:0]   res_den_o;
  logic                  status_o;
  int                    fail_cnt;
  int                    pending;
  int                    idle_cycles = 0;

  rational_mixed_fraction_alu uut (
    .clk_i, .rst_ni, .start, .busy, .op_i, .a_num_i, .a_den_i, .b_num_i, .b_den_i,
    .done_o, .whole_o, .rem_num_o, .res_den_o, .status_o
  );

  rational_mixed_fraction_alu_checker checker_i (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .op_i, .a_num_i, .a_den_i,
    .b_num_i, .b_den_i, .done_i(done_o), .whole_i(whole_o), .rem_num_i(rem_num_o),
    .res_den_i(res_den_o), .status_i(status_o), .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // watchdog on cycles with nothing accepted and no result
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // random operand biased toward small values, signs and edges
  function automatic logic [FieldWidth-1:0] rand_field();
    case ($urandom_range(0, 5))
      0: return FieldWidth'($urandom);
      1: return FieldWidth'($urandom_range(0, 6)) - FieldWidth'(3);
      2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      3: return FieldWidth'($urandom_range(0, 40));
      4: return -FieldWidth'($urandom_range(0, 40));
      default: return FieldWidth'($urandom_range(0, 1000)) - FieldWidth'(500);
    endcase
  endfunction

  // present one request and hold it until taken
  task automatic send_request(op_e op, logic [FieldWidth-1:0] an, logic [FieldWidth-1:0] ad,
                              logic [FieldWidth-1:0] bn, logic [FieldWidth-1:0] bd);
    start   <= 1'b1;
    op_i    <= op;
    a_num_i <= an;
    a_den_i <= ad;
    b_num_i <= bn;
    b_den_i <= bd;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic pause(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  initial begin
    int burst;
    start = 1'b0; op_i = '0; a_num_i = '0; a_den_i = '0; b_num_i = '0; b_den_i = '0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every op, extremes, zero denominators, zero numerator, divide by zero
    for (int o = 0; o < 4; o++) begin
      send_request(op_e'(o), 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_request(op_e'(o), 16'h7fff, 16'h0001, 16'h8000, 16'h7fff);
      send_request(op_e'(o), 16'h0000, 16'h0005, 16'h0003, 16'hfffd);
    end
    send_request(OpAdd, 16'h0003, 16'h0000, 16'h0001, 16'h0002);
    send_request(OpMul, 16'h0003, 16'h0002, 16'h0001, 16'h0000);
    send_request(OpDiv, 16'h0003, 16'h0002, 16'h0000, 16'h0007);
    send_request(OpDiv, 16'h8000, 16'h0001, 16'hffff, 16'h0001);
    send_request(OpSub, 16'h0001, 16'h0003, 16'h0001, 16'h0003);
    send_request(OpSub, 16'hfff9, 16'h0002, 16'h0005, 16'hfffd);
    send_request(OpAdd, 16'h7fff, 16'h8001, 16'h8000, 16'h7fff);
    pause(1);

    // random bursts with random gaps
    for (int n = 0; n < 1100; n += burst) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst; k++)
        send_request(op_e'($urandom_range(0, 3)), rand_field(), rand_field(), rand_field(),
                     rand_field());
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 150));
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_cnt == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
src/rmf_pkg.sv
src/rmf_front.sv
src/rmf_queue.sv
src/rmf_back.sv
src/rational_mixed_fraction_alu.sv
verif/rational_mixed_fraction_alu_checker.sv
verif/rational_mixed_fraction_alu_tb.sv
